@@ src/smvcsr_pkg.sv @@
// shared types and constants for the sparse matrix-vector row accumulator
`default_nettype none

package smvcsr_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NONZERO = 2'd1;
  localparam logic [1:0] OP_EMPTY   = 2'd2;

  // q16.16 saturation limits
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  // one finished row
  typedef struct packed {
    logic [31:0] row_sum;
    logic [11:0] row_number;
    logic        saturated;
  } result_t;

  // queue status toward the top level
  typedef struct packed {
    logic               out_valid;
    logic [FIFO_CW-1:0] count;
  } fifo_status_t;

endpackage : smvcsr_pkg

`default_nettype wire

@@ src/sparse_matvec_csr_row_accumulate.sv @@
// top level: csr sparse matrix times dense vector with per-row q16.16 accumulation
//
// Input channel (in_valid / in_stall) carries one transaction per cycle while
// in_stall is low: a vector load, a matrix nonzero or an empty-row marker. Output
// channel (out_valid / out_stall) carries one transaction per finished row (sum,
// row number, flag), none for an empty row in accumulate mode. The config channel
// (cfg_valid / cfg_ready, always ready) writes accumulate_mode; write it only
// while no transaction is in flight. Throughput: one input transaction per cycle
// while in_stall is low, set by the single-port vector store read and the one
// multiply-accumulate per cycle on the row register. Results pass the store read
// and first stage, the product register, then saturate and accumulate into the queue.
// A stalled output fills a 4-entry result queue; in_stall rises once the queue
// plus the transactions still in the pipe could overflow it.
// Reset clears the row sum, flag, row counter, mode and queue; the vector store
// holds garbage until loaded.
`default_nettype none

module sparse_matvec_csr_row_accumulate
  import smvcsr_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = 4096
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  // config write
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_data,
  // input transactions
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [11:0]        position,
  input  wire logic signed [31:0] value,
  input  wire logic               row_first,
  input  wire logic               row_last,
  input  wire logic signed [31:0] prior_sum,
  // output transactions
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [31:0] row_sum,
  output      logic [11:0]        row_number,
  output      logic               saturated
);

  localparam int unsigned AW = $clog2(VECTOR_DEPTH);

  // vector store
  logic [31:0]   vector_store [VECTOR_DEPTH];
  logic [31:0]   rd_data;
  logic [31:0]   pos_ext;
  logic [AW-1:0] addr;
  logic          pos_in_range;
  logic          accept;

  // first stage
  logic          s1_valid;
  logic [1:0]    s1_op;
  logic [31:0]   s1_value;
  logic          s1_first;
  logic          s1_last;
  logic [31:0]   s1_prior;
  logic          s1_in_range;
  logic signed [31:0] s1_mult_a;
  logic signed [31:0] s1_mult_b;

  // second stage
  logic          s2_valid;
  logic [1:0]    s2_op;
  logic          s2_first;
  logic          s2_last;
  logic [31:0]   s2_prior;
  logic signed [63:0] s2_prod;

  // row state
  logic          accumulate_mode;
  logic [31:0]   acc;
  logic          flag;
  logic [11:0]   row_counter;

  // accumulate datapath
  logic [31:0]   base;
  logic          base_flag;
  logic [16:0]   prod_hi;
  logic          prod_ovf;
  logic [31:0]   prod_sat;
  logic [32:0]   sum_wide;
  logic          sum_ovf;
  logic [31:0]   sum;
  logic          flag_new;

  // result queue
  logic          push;
  result_t       push_data;
  logic          pop;
  fifo_status_t  fifo_status;
  result_t       head;
  logic [3:0]    occupancy;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulate_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      accumulate_mode <= cfg_data;
    end
  end

  // input handshake and store address
  assign occupancy    = {1'b0, fifo_status.count} + {3'b0, s1_valid} + {3'b0, s2_valid};
  assign in_stall     = (occupancy >= 4'(FIFO_DEPTH));
  assign accept       = in_valid && !in_stall;
  assign pos_ext      = 32'(position);
  assign addr         = pos_ext[AW-1:0];
  assign pos_in_range = (pos_ext < 32'(VECTOR_DEPTH));

  // store write on load, registered read every cycle
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_LOAD) && pos_in_range) begin
      vector_store[addr] <= value;
    end
    rd_data <= vector_store[addr];
  end

  // first stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_op       <= operation;
    s1_value    <= value;
    s1_first    <= row_first;
    s1_last     <= row_last;
    s1_prior    <= prior_sum;
    s1_in_range <= pos_in_range;
  end

  // multiply by the stored entry, zero beyond the store
  assign s1_mult_a = signed'(s1_value);
  assign s1_mult_b = s1_in_range ? signed'(rd_data) : 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_op    <= s1_op;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_prior <= s1_prior;
    s2_prod  <= s1_mult_a * s1_mult_b;
  end

  // row start selects the seed
  assign base      = s2_first ? (accumulate_mode ? s2_prior : 32'd0) : acc;
  assign base_flag = s2_first ? 1'b0 : flag;

  // floor shift by 16 and saturate the product
  assign prod_hi  = s2_prod[63:47];
  assign prod_ovf = !((&prod_hi) || (~|prod_hi));
  assign prod_sat = prod_ovf ? (s2_prod[63] ? Q_MIN : Q_MAX) : s2_prod[47:16];

  // saturating add into the row
  assign sum_wide = {base[31], base} + {prod_sat[31], prod_sat};
  assign sum_ovf  = sum_wide[32] ^ sum_wide[31];
  assign sum      = sum_ovf ? (sum_wide[32] ? Q_MIN : Q_MAX) : sum_wide[31:0];
  assign flag_new = base_flag || prod_ovf || sum_ovf;

  // row accumulator, flag and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      flag        <= 1'b0;
      row_counter <= '0;
    end else if (s2_valid) begin
      case (s2_op)
        OP_NONZERO: begin
          if (s2_last) begin
            acc         <= '0;
            flag        <= 1'b0;
            row_counter <= row_counter + 1'b1;
          end else begin
            acc  <= sum;
            flag <= flag_new;
          end
        end
        OP_EMPTY: begin
          acc         <= '0;
          flag        <= 1'b0;
          row_counter <= row_counter + 1'b1;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // result push
  always_comb begin
    push                 = 1'b0;
    push_data.row_sum    = sum;
    push_data.row_number = row_counter;
    push_data.saturated  = flag_new;
    case (s2_op)
      OP_NONZERO: begin
        push = s2_valid && s2_last;
      end
      OP_EMPTY: begin
        push                = s2_valid && !accumulate_mode;
        push_data.row_sum   = '0;
        push_data.saturated = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign pop = fifo_status.out_valid && !out_stall;

  smvcsr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .status    (fifo_status),
    .head      (head)
  );

  // output ports
  assign out_valid  = fifo_status.out_valid;
  assign row_sum    = signed'(head.row_sum);
  assign row_number = head.row_number;
  assign saturated  = head.saturated;

endmodule : sparse_matvec_csr_row_accumulate

`default_nettype wire

@@ src/smvcsr_out_fifo.sv @@
// small result queue that decouples the accumulator from the output stall
`default_nettype none

module smvcsr_out_fifo
  import smvcsr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire result_t      push_data,
  input  wire logic         pop,
  output fifo_status_t      status,
  output result_t           head
);

  result_t              entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head             = entries[rd_ptr];
  assign status.out_valid = (count != '0);
  assign status.count     = count;

endmodule : smvcsr_out_fifo

`default_nettype wire

@@ tb/sv/sparse_matvec_csr_row_accumulate_tb.sv @@
// testbench for the csr sparse matrix-vector row accumulator, self-checking
`timescale 1ns / 1ps

module sparse_matvec_csr_row_accumulate_tb;
  import smvcsr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int VEC_DEPTH = 4096;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 400;

  // one input transaction
  typedef struct {
    logic [1:0]  op;
    logic [11:0] pos;
    int          value;
    bit          first;
    bit          last;
    int          prior;
  } txn_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         operation;
  logic [11:0]        position;
  logic signed [31:0] value;
  logic               row_first;
  logic               row_last;
  logic signed [31:0] prior_sum;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] row_sum;
  logic [11:0]        row_number;
  logic               saturated;

  // shadow copy of the block state
  int        vec_copy [VEC_DEPTH];
  bit        vec_written [VEC_DEPTH];
  int        written_cols [$];
  int        row_acc = 0;
  bit [11:0] row_idx = '0;
  bit        row_sat = 1'b0;
  bit        acc_mode = 1'b0;

  result_t pending_rows [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  rows_checked = 0;
  int  rows_saturated = 0;
  int  quiet_cycles = 0;
  bit  in_tight = 1'b0;
  bit  out_tight = 1'b0;

  sparse_matvec_csr_row_accumulate uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .row_first  (row_first),
    .row_last   (row_last),
    .prior_sum  (prior_sum),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_sum    (row_sum),
    .row_number (row_number),
    .saturated  (saturated)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // q16.16 clamp, marks the row on overflow
  function automatic int clamp_q(input longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  // update the shadow state for one transaction and queue any finished row
  task automatic predict_row_sum(input txn_t t);
    longint  prod;
    int      term;
    result_t r;
    case (t.op)
      OP_LOAD: begin
        vec_copy[t.pos] = t.value;
        if (!vec_written[t.pos]) begin
          vec_written[t.pos] = 1'b1;
          written_cols.push_back(int'(t.pos));
        end
      end
      OP_NONZERO: begin
        if (t.first) begin
          row_acc = acc_mode ? t.prior : 0;
          row_sat = 1'b0;
        end
        // floor of the exact product, then clamp product and sum
        prod = (longint'(t.value) * longint'(vec_copy[t.pos])) >>> 16;
        term = clamp_q(prod, row_sat);
        row_acc = clamp_q(longint'(row_acc) + longint'(term), row_sat);
        if (t.last) begin
          r.row_sum = row_acc;
          r.row_number = row_idx;
          r.saturated = row_sat;
          pending_rows.push_back(r);
          row_acc = 0;
          row_sat = 1'b0;
          row_idx++;
        end
      end
      OP_EMPTY: begin
        row_acc = 0;
        row_sat = 1'b0;
        if (!acc_mode) begin
          r.row_sum = '0;
          r.row_number = row_idx;
          r.saturated = 1'b0;
          pending_rows.push_back(r);
        end
        row_idx++;
      end
      default: ;
    endcase
  endtask

  function automatic txn_t mk(input logic [1:0] op, input int pos, input int val,
                              input int first, input int last, input int prior);
    txn_t t;
    t.op = op;
    t.pos = pos[11:0];
    t.value = val;
    t.first = first[0];
    t.last = last[0];
    t.prior = prior;
    return t;
  endfunction

  // q16.16 value: full range, small, medium or a corner value
  function automatic int rand_q();
    case ($urandom_range(3))
      0: return int'($urandom);
      1: return int'($urandom_range(262143)) - 131072;
      2: return int'($urandom_range(16777215)) - 8388608;
      default: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 0;
          3: return -1;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  // column that has been loaded since reset
  function automatic int pick_col();
    return written_cols[$urandom_range(written_cols.size() - 1)];
  endfunction

  // send one transaction, with a random idle gap ahead of it
  task automatic send_txn(input txn_t t);
    int gap;
    gap = in_tight ? 0 : $urandom_range(5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= t.op;
    position <= t.pos;
    value <= t.value;
    row_first <= t.first;
    row_last <= t.last;
    prior_sum <= t.prior;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_row_sum(t);
    if (t.op != OP_UNUSED) items_sent++;
  endtask

  // stop sending and let every expected row and the pipe drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // accumulate_mode write, only while idle
  task automatic write_mode(input bit m);
    wait_idle();
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    acc_mode = m;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // plain mode: extremes, floor rounding, saturation, empty and broken rows
  task automatic test_directed_plain();
    write_mode(1'b0);
    send_txn(mk(OP_LOAD, 0, 32'h0001_0000, 0, 0, 0));
    send_txn(mk(OP_LOAD, 4095, 32'h7fff_ffff, 0, 0, 0));
    send_txn(mk(OP_LOAD, 1, 32'h8000_0000, 0, 0, 0));
    send_txn(mk(OP_LOAD, 2, 32'h0000_0001, 0, 0, 0));
    send_txn(mk(OP_NONZERO, 0, 32'h0002_0000, 1, 1, 0));
    send_txn(mk(OP_NONZERO, 4095, 32'h7fff_ffff, 1, 1, 32'h7fff_ffff));
    // product overflow both ways within one row
    send_txn(mk(OP_NONZERO, 1, 32'h8000_0000, 1, 0, 0));
    send_txn(mk(OP_NONZERO, 1, 32'h7fff_ffff, 0, 1, 0));
    // negative product rounds toward minus infinity
    send_txn(mk(OP_NONZERO, 2, -1, 1, 1, 0));
    send_txn(mk(OP_EMPTY, 0, 0, 0, 0, 0));
    // open row dropped by an empty row
    send_txn(mk(OP_NONZERO, 0, 32'h0005_0000, 1, 0, 0));
    send_txn(mk(OP_EMPTY, 4095, -1, 1, 1, -1));
    // row with no start mark begins from zero
    send_txn(mk(OP_NONZERO, 0, 32'h0001_0000, 0, 1, 0));
    send_txn(mk(OP_UNUSED, 4095, -1, 1, 1, -1));
    // sum overflow
    send_txn(mk(OP_NONZERO, 4095, 32'h7fff_ffff, 1, 0, 0));
    send_txn(mk(OP_NONZERO, 0, 32'h0001_0000, 0, 1, 0));
  endtask

  // accumulate mode: seeded rows, seed overflow, suppressed empty rows
  task automatic test_directed_accumulate();
    write_mode(1'b1);
    send_txn(mk(OP_NONZERO, 0, 32'h0001_0000, 1, 1, 32'h7fff_0000));
    send_txn(mk(OP_NONZERO, 2, -1, 1, 1, 32'h8000_0000));
    send_txn(mk(OP_EMPTY, 0, 0, 0, 0, 0));
    send_txn(mk(OP_NONZERO, 0, 32'h0003_0000, 1, 0, 32'h0001_0000));
    send_txn(mk(OP_NONZERO, 0, 32'h0001_0000, 0, 1, 32'h7fff_ffff));
    send_txn(mk(OP_NONZERO, 0, 32'h0001_0000, 0, 1, 32'h1234_5678));
    send_txn(mk(OP_NONZERO, 4095, 32'h7fff_ffff, 1, 0, 32'h0100_0000));
    send_txn(mk(OP_EMPTY, 0, 0, 0, 0, 0));
    send_txn(mk(OP_UNUSED, 0, 0, 0, 1, 0));
  endtask

  // random rows, mostly well formed, under alternating mode settings
  task automatic test_random_rows();
    int kind;
    int len;
    int target;
    in_tight = 1'b0;
    repeat (160) send_txn(mk(OP_LOAD, $urandom_range(4095), rand_q(), 0, 0, 0));
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase[0]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(19) == 0) in_tight = !in_tight;
        kind = $urandom_range(99);
        if (kind < 8) begin
          send_txn(mk(OP_LOAD, $urandom_range(4095), rand_q(), $urandom_range(1),
                      $urandom_range(1), int'($urandom)));
        end else if (kind < 14) begin
          send_txn(mk(OP_EMPTY, $urandom_range(4095), int'($urandom), $urandom_range(1),
                      $urandom_range(1), int'($urandom)));
        end else if (kind < 17) begin
          send_txn(mk(OP_UNUSED, $urandom_range(4095), int'($urandom), $urandom_range(1),
                      $urandom_range(1), int'($urandom)));
        end else if (kind < 25) begin
          // stray nonzero with arbitrary row marks
          send_txn(mk(OP_NONZERO, pick_col(), rand_q(), $urandom_range(1),
                      $urandom_range(1), rand_q()));
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++)
            send_txn(mk(OP_NONZERO, pick_col(), rand_q(), int'(i == 0),
                        int'(i == len - 1), rand_q()));
        end
      end
    end
    in_tight = 1'b0;
  endtask

  // output side: random stall ahead of each result, with stall-free stretches
  initial begin : result_sink
    int n;
    forever begin
      if ($urandom_range(39) == 0) out_tight = !out_tight;
      n = out_tight ? 0 : $urandom_range(5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // compare each accepted result with the oldest expected row
  always @(posedge clk) begin : row_check
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      rows_checked++;
      if (saturated === 1'b1) rows_saturated++;
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected row result", row_sum, '0);
      end else begin
        want = pending_rows.pop_front();
        if (row_sum !== want.row_sum) report_mismatch("row_sum", row_sum, want.row_sum);
        if (row_number !== want.row_number)
          report_mismatch("row_number", 32'(row_number), 32'(want.row_number));
        if (saturated !== want.saturated)
          report_mismatch("saturated", 32'(saturated), 32'(want.saturated));
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d rows still expected", pending_rows.size());
      $display("[sparse_matvec_csr_row_accumulate] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    operation <= OP_LOAD;
    position <= '0;
    value <= '0;
    row_first <= 1'b0;
    row_last <= 1'b0;
    prior_sum <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_plain();
    test_directed_accumulate();
    test_random_rows();
    wait_idle();
    if (pending_rows.size() != 0) report_mismatch("rows never produced", '0, '0);
    $display("covered %0d input transactions, %0d rows checked, %0d of them saturated",
             items_sent, rows_checked, rows_saturated);
    $display("both accumulate settings, empty and broken rows, floor rounding, saturation");
    if (mismatches == 0) begin
      $display("[sparse_matvec_csr_row_accumulate] OK");
    end else begin
      $display("[sparse_matvec_csr_row_accumulate] ERROR");
    end
    $finish;
  end

endmodule
